>>> hdl/fcc_pkg.sv
// Shared types and constants for the four-function calculator engine.
`default_nettype none

package fcc_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_WIDTH   = $clog2(VALUE_WIDTH);
  localparam logic [VALUE_WIDTH-1:0] TEN     = VALUE_WIDTH'(10);
  localparam logic [VALUE_WIDTH-1:0] MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    KEY_DIGIT  = 2'd0,
    KEY_OPER   = 2'd1,
    KEY_EQUALS = 2'd2,
    KEY_CLEAR  = 2'd3
  } key_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] digit_value;
    logic [1:0] operator_code;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] shown_value;
    logic                          overflow;
  } res_t;

  // Classified key as it travels from the front to the back.
  typedef struct packed {
    key_e       key;
    logic [3:0] digit;
    op_e        next_op;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_sts_t;

endpackage

`default_nettype wire

>>> hdl/fcc_front.sv
// Key intake: classifies each keypress and queues it for execution.
`default_nettype none

module fcc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  fcc_pkg::req_t     req_i,
  output logic              cmd_valid_o,
  output fcc_pkg::cmd_t     cmd_o,
  input  fcc_pkg::back_sts_t sts_i
);

  fcc_pkg::cmd_t cmd_in;
  fcc_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push;

  always_comb begin
    cmd_in.key   = fcc_pkg::key_e'(req_i.req_type);
    cmd_in.digit = req_i.digit_value;
    if (cmd_in.key == fcc_pkg::KEY_OPER) begin
      cmd_in.next_op = fcc_pkg::op_e'({1'b0, req_i.operator_code} + 3'd1);
    end else begin
      cmd_in.next_op = fcc_pkg::OP_NONE;
    end
  end

  assign req_stall_o = (count_q == 2'd2);
  assign push        = req_valid_i && !req_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = sts_i.pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, sts_i.pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> hdl/fcc_back.sv
// Executor: holds the calculator state and carries out one key at a time.
`default_nettype none

module fcc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  fcc_pkg::cmd_t      cmd_i,
  output fcc_pkg::back_sts_t sts_o,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output fcc_pkg::res_t      res_o
);

  localparam int unsigned W = fcc_pkg::VALUE_WIDTH;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_DIGIT  = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DIVFIX = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [W-1:0]                 acc_q, acc_d;
  logic [W-1:0]                 entry_q, entry_d;
  fcc_pkg::op_e                 pend_q, pend_d;
  fcc_pkg::cmd_t                cmd_q, cmd_d;
  logic signed [2*W-1:0]        prod_q, prod_d;
  logic [W-1:0]                 rem_q, rem_d;
  logic [W-1:0]                 quo_q, quo_d;
  logic [W-1:0]                 dvs_q, dvs_d;
  logic                         neg_q, neg_d;
  logic [fcc_pkg::CNT_WIDTH-1:0] cnt_q, cnt_d;
  fcc_pkg::res_t                out_q, out_d;
  logic                         out_vld_q, out_vld_d;

  logic                         pop;
  logic signed [W-1:0]          mul_a, mul_b;
  logic signed [2*W-1:0]        mul_full;
  logic [W-1:0]                 sum, diff, mag_a, mag_b, quo_fix, dig_sum;
  logic [W:0]                   shifted, trial;
  logic [W:0]                   prod_hi;
  logic                         prod_ovf;

  assign pop = (state_q == ST_IDLE) && cmd_valid_i && (!out_vld_q || !res_stall_i);
  assign sts_o.pop  = pop;
  assign sts_o.busy = (state_q != ST_IDLE);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  // Digit keys scale the entry by ten, settles multiply accumulator by entry.
  assign mul_a    = (cmd_i.key == fcc_pkg::KEY_DIGIT) ? entry_q : acc_q;
  assign mul_b    = (cmd_i.key == fcc_pkg::KEY_DIGIT) ? fcc_pkg::TEN : entry_q;
  assign mul_full = mul_a * mul_b;

  assign sum     = acc_q + entry_q;
  assign diff    = acc_q - entry_q;
  assign mag_a   = acc_q[W-1] ? (~acc_q + 1'b1) : acc_q;
  assign mag_b   = entry_q[W-1] ? (~entry_q + 1'b1) : entry_q;
  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign quo_fix = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign dig_sum = prod_q[W-1:0] + W'(cmd_q.digit);

  // The product fits when its upper half plus sign bit are all equal.
  assign prod_hi   = prod_q[2*W-1:W-1];
  assign prod_ovf  = !((&prod_hi) || !(|prod_hi));

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    entry_d   = entry_q;
    pend_d    = pend_q;
    cmd_d     = cmd_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && res_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          cmd_d = cmd_i;
          unique case (cmd_i.key)
            fcc_pkg::KEY_CLEAR: begin
              acc_d     = '0;
              entry_d   = '0;
              pend_d    = fcc_pkg::OP_NONE;
              out_d     = '0;
              out_vld_d = 1'b1;
            end
            fcc_pkg::KEY_DIGIT: begin
              prod_d  = mul_full;
              state_d = ST_DIGIT;
            end
            default: begin
              case (pend_q)
                fcc_pkg::OP_ADD: begin
                  acc_d          = sum;
                  out_d.shown_value = sum;
                  out_d.overflow = (acc_q[W-1] == entry_q[W-1]) && (sum[W-1] != acc_q[W-1]);
                  entry_d        = '0;
                  pend_d         = cmd_i.next_op;
                  out_vld_d      = 1'b1;
                end
                fcc_pkg::OP_SUB: begin
                  acc_d          = diff;
                  out_d.shown_value = diff;
                  out_d.overflow = (acc_q[W-1] != entry_q[W-1]) && (diff[W-1] != acc_q[W-1]);
                  entry_d        = '0;
                  pend_d         = cmd_i.next_op;
                  out_vld_d      = 1'b1;
                end
                fcc_pkg::OP_MUL: begin
                  prod_d  = mul_full;
                  state_d = ST_MUL;
                end
                fcc_pkg::OP_DIV: begin
                  if (entry_q == '0) begin
                    acc_d     = '0;
                    out_d     = '0;
                    entry_d   = '0;
                    pend_d    = cmd_i.next_op;
                    out_vld_d = 1'b1;
                  end else if (acc_q == fcc_pkg::MIN_VAL && (&entry_q)) begin
                    acc_d             = fcc_pkg::MIN_VAL;
                    out_d.shown_value = fcc_pkg::MIN_VAL;
                    out_d.overflow    = 1'b1;
                    entry_d           = '0;
                    pend_d            = cmd_i.next_op;
                    out_vld_d         = 1'b1;
                  end else begin
                    rem_d   = '0;
                    quo_d   = mag_a;
                    dvs_d   = mag_b;
                    neg_d   = acc_q[W-1] ^ entry_q[W-1];
                    cnt_d   = fcc_pkg::CNT_WIDTH'(W - 1);
                    state_d = ST_DIV;
                  end
                end
                default: begin
                  // Nothing pending: take the entry as it is.
                  acc_d             = entry_q;
                  out_d.shown_value = entry_q;
                  out_d.overflow    = 1'b0;
                  entry_d           = '0;
                  pend_d            = cmd_i.next_op;
                  out_vld_d         = 1'b1;
                end
              endcase
            end
          endcase
        end
      end
      ST_MUL: begin
        acc_d             = prod_q[W-1:0];
        out_d.shown_value = prod_q[W-1:0];
        out_d.overflow    = prod_ovf;
        entry_d           = '0;
        pend_d            = cmd_q.next_op;
        out_vld_d         = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_DIGIT: begin
        entry_d           = dig_sum;
        out_d.shown_value = dig_sum;
        out_d.overflow    = prod_ovf || (!prod_q[W-1] && dig_sum[W-1]);
        out_vld_d         = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_DIV: begin
        // One restoring step per cycle, quotient bits shift in at the bottom.
        if (!trial[W]) begin
          rem_d = trial[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = shifted[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DIVFIX;
        end
      end
      ST_DIVFIX: begin
        acc_d             = quo_fix;
        out_d.shown_value = quo_fix;
        out_d.overflow    = 1'b0;
        entry_d           = '0;
        pend_d            = cmd_q.next_op;
        out_vld_d         = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_q     <= '0;
      entry_q   <= '0;
      pend_q    <= fcc_pkg::OP_NONE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      entry_q   <= entry_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

>>> hdl/four_function_calculator_engine.sv
// Four-function calculator engine: keypress intake, key queue and executor.
// A key reaches the result register in the cycle after acceptance for clear, add, subtract,
// a settle with nothing pending and a divide by zero or MIN_VAL by -1. Digit and multiply
// go via the product register; other divides run the one-bit-per-cycle restoring divider.
// The executor takes one key at a time; a two-entry queue keeps intake open meanwhile.
// Reset clears accumulator, entry and pending operator to zero and empties the queue.
`default_nettype none

module four_function_calculator_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  fcc_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_stall_i,
  output fcc_pkg::res_t res_o
);

  logic               cmd_valid;
  fcc_pkg::cmd_t      cmd;
  fcc_pkg::back_sts_t sts;

  fcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.pop |-> cmd_valid)
    else $error("executor took a key from an empty queue");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> !sts.pop)
    else $error("executor took a key while busy");

  a_digit_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.pop && (cmd.key == fcc_pkg::KEY_DIGIT) |=> sts.busy)
    else $error("digit key did not enter the multiply step");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(sts.busy || sts.pop))
    else $error("result beat appeared without a key in execution");
`endif

endmodule

`default_nettype wire
